// ----- rtl/assert_macros.svh -----
// assertion macros shared by the connection control rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define TCC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tcc assertion failed");

// implication checked on every rising clock edge outside reset
`define TCC_ASSERT_IMPL(name, clk, rst, ante, cons) \
   `TCC_ASSERT(name, clk, rst, (ante) |-> (cons))

`endif

// ----- rtl/tcc_pkg.sv -----
// types and constants of the tcp connection control unit
package tcc_pkg;

   localparam logic [7:0] FL_FIN      = 8'h01;
   localparam logic [7:0] FL_SYN      = 8'h02;
   localparam logic [7:0] FL_RST      = 8'h04;
   localparam logic [7:0] FL_ACK      = 8'h10;
   localparam logic [7:0] FL_RELEVANT = FL_FIN | FL_SYN | FL_RST | FL_ACK;
   localparam logic [7:0] FL_SYNACK   = FL_SYN | FL_ACK;

   localparam int unsigned RST_BIT = 2;

   localparam logic [1:0] OP_SEGMENT = 2'd0;
   localparam logic [1:0] OP_ACCEPT  = 2'd1;
   localparam logic [1:0] OP_CONNECT = 2'd2;

   localparam logic [2:0] PH_IDLE          = 3'd0;
   localparam logic [2:0] PH_CONNECTING    = 3'd1;
   localparam logic [2:0] PH_ACCEPTING     = 3'd2;
   localparam logic [2:0] PH_ESTABLISHED   = 3'd3;
   localparam logic [2:0] PH_PASSIVE_CLOSE = 3'd4;
   localparam logic [2:0] PH_DEAD          = 3'd5;

   localparam logic [1:0] CSR_LOCAL_PORT     = 2'd0;
   localparam logic [1:0] CSR_REMOTE_PORT    = 2'd1;
   localparam logic [1:0] CSR_RECEIVE_WINDOW = 2'd2;

   // everything one event produces; two marks the ack then fin pair
   typedef struct packed {
      logic        vld;
      logic [7:0]  flags;
      logic [31:0] seq;
      logic [31:0] ack;
      logic        deliver;
      logic        dead;
      logic [2:0]  phase;
      logic        two;
   } rec_type;

   // one result word as presented on the output side
   typedef struct packed {
      logic        vld;
      logic [7:0]  flags;
      logic [31:0] seq;
      logic [31:0] ack;
      logic        deliver;
      logic        dead;
      logic [2:0]  phase;
      logic        last;
   } word_type;

endpackage

// ----- rtl/tcc_engine.sv -----
// connection state registers and the per-event decision logic
`include "assert_macros.svh"

module tcc_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [1:0]       operation,
   input  logic [7:0]       seg_flags,
   input  logic [31:0]      seg_seq,
   input  logic [31:0]      seg_ack,
   input  logic [15:0]      payload_len,
   input  logic [31:0]      initial_seq,
   output tcc_pkg::rec_type rec
);

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] recv_seq_ff, recv_seq_in;
   logic [31:0] send_seq_ff, send_seq_in;
   logic [7:0]  rel;
   logic [31:0] seq_p1;
   logic [31:0] ack_p1;
   logic [31:0] recv_adv;

   assign rel      = seg_flags & tcc_pkg::FL_RELEVANT;
   assign seq_p1   = seg_seq + 32'd1;
   assign ack_p1   = seg_ack + 32'd1;
   assign recv_adv = recv_seq_ff + {16'd0, payload_len};

   always_comb begin
      phase_in    = phase_ff;
      recv_seq_in = recv_seq_ff;
      send_seq_in = send_seq_ff;
      rec         = '0;
      unique case (operation)
         tcc_pkg::OP_ACCEPT: begin
            phase_in    = tcc_pkg::PH_ACCEPTING;
            recv_seq_in = seq_p1;
            send_seq_in = initial_seq;
            rec.vld     = 1'b1;
            rec.flags   = tcc_pkg::FL_SYNACK;
            rec.seq     = initial_seq;
            rec.ack     = seq_p1;
         end
         tcc_pkg::OP_CONNECT: begin
            phase_in    = tcc_pkg::PH_CONNECTING;
            send_seq_in = initial_seq;
            rec.vld     = 1'b1;
            rec.flags   = tcc_pkg::FL_SYN;
            rec.seq     = initial_seq;
         end
         tcc_pkg::OP_SEGMENT: begin
            priority if (seg_flags[tcc_pkg::RST_BIT]) begin
               phase_in = tcc_pkg::PH_DEAD;
               rec.dead = 1'b1;
            end else if (phase_ff == tcc_pkg::PH_ESTABLISHED) begin
               priority if (rel == tcc_pkg::FL_FIN) begin
                  phase_in  = tcc_pkg::PH_PASSIVE_CLOSE;
                  rec.vld   = 1'b1;
                  rec.flags = tcc_pkg::FL_ACK;
                  rec.seq   = ack_p1;
                  rec.ack   = seq_p1;
                  rec.two   = 1'b1;
               end else if (payload_len != 16'd0) begin
                  // plain unsigned compare, no wrap-aware window
                  priority if (seg_seq < recv_seq_ff) begin
                     rec.vld   = 1'b1;
                     rec.flags = tcc_pkg::FL_ACK;
                     rec.seq   = send_seq_ff;
                     rec.ack   = recv_seq_ff;
                  end else if (seg_seq == recv_seq_ff) begin
                     recv_seq_in = recv_adv;
                     rec.deliver = 1'b1;
                     rec.vld     = 1'b1;
                     rec.flags   = tcc_pkg::FL_ACK;
                     rec.seq     = send_seq_ff;
                     rec.ack     = recv_adv;
                  end else begin
                     // ahead of the receive sequence: dropped
                  end
               end else begin
               end
            end else if (phase_ff == tcc_pkg::PH_ACCEPTING) begin
               if (rel == tcc_pkg::FL_ACK) begin
                  phase_in    = tcc_pkg::PH_ESTABLISHED;
                  recv_seq_in = seg_seq;
                  send_seq_in = seg_ack;
               end
            end else if (phase_ff == tcc_pkg::PH_CONNECTING) begin
               if (rel == tcc_pkg::FL_SYNACK) begin
                  phase_in    = tcc_pkg::PH_ESTABLISHED;
                  recv_seq_in = seq_p1;
                  send_seq_in = ack_p1;
                  rec.vld     = 1'b1;
                  rec.flags   = tcc_pkg::FL_ACK;
                  rec.seq     = ack_p1;
                  rec.ack     = seq_p1;
               end
            end else if (phase_ff == tcc_pkg::PH_PASSIVE_CLOSE) begin
               if (rel == tcc_pkg::FL_ACK) begin
                  phase_in = tcc_pkg::PH_DEAD;
                  rec.dead = 1'b1;
               end
            end else begin
               // idle, dead and unused codes ignore segments that carry no rst
            end
         end
         default: begin
         end
      endcase
      rec.phase = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= tcc_pkg::PH_IDLE;
         recv_seq_ff <= '0;
         send_seq_ff <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         recv_seq_ff <= recv_seq_in;
         send_seq_ff <= send_seq_in;
      end
   end

   `TCC_ASSERT_IMPL(a_rst_kills, clock, reset,
      accept && operation == tcc_pkg::OP_SEGMENT && seg_flags[tcc_pkg::RST_BIT],
      ##1 phase_ff == tcc_pkg::PH_DEAD)
   `TCC_ASSERT_IMPL(a_pair_only_fin, clock, reset,
      rec.two, phase_ff == tcc_pkg::PH_ESTABLISHED && rec.phase == tcc_pkg::PH_PASSIVE_CLOSE)

endmodule

// ----- rtl/tcc_rspq.sv -----
// two-entry result queue that unrolls each event into one or two words
`include "assert_macros.svh"

module tcc_rspq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcc_pkg::rec_type  push_rec,
   output logic              has_room,
   output logic              word_valid,
   input  logic              word_ready,
   output tcc_pkg::word_type word
);

   tcc_pkg::rec_type entry_ff [2];
   logic       head_ff, head_in;
   logic       tail_ff, tail_in;
   logic [1:0] count_ff, count_in;
   logic       sub_ff, sub_in;
   logic       pop;
   logic       take;
   tcc_pkg::rec_type head_rec;

   assign head_rec   = entry_ff[head_ff];
   assign has_room   = (count_ff != 2'd2);
   assign word_valid = (count_ff != 2'd0);
   assign take       = word_valid && word_ready;
   assign pop        = take && (!head_rec.two || sub_ff);

   always_comb begin
      word.vld     = head_rec.vld;
      word.flags   = sub_ff ? tcc_pkg::FL_FIN : head_rec.flags;
      word.seq     = head_rec.seq;
      word.ack     = head_rec.ack;
      word.deliver = head_rec.deliver;
      word.dead    = head_rec.dead;
      word.phase   = head_rec.phase;
      word.last    = !head_rec.two || sub_ff;
   end

   always_comb begin
      head_in  = pop ? ~head_ff : head_ff;
      tail_in  = push ? ~tail_ff : tail_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      sub_in   = sub_ff;
      if (pop) begin
         sub_in = 1'b0;
      end else if (take) begin
         sub_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         count_ff <= 2'd0;
         sub_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_rec;
      end
   end

   `TCC_ASSERT(a_count_bound, clock, reset, count_ff != 2'd3)
   `TCC_ASSERT_IMPL(a_second_word, clock, reset, sub_ff, word_valid && head_rec.two)

endmodule

// ----- rtl/tcp_connection_control_unit.sv -----
// tcp connection control unit top level: csr registers, event path and result port
//
// One event word is taken per cycle while the two-entry result queue has room;
// its phase, receive and send sequence effects are applied in the cycle it is
// accepted, and its result is written into the result queue, from which the rsp
// side presents it. Every event gives one result word except a bare fin while
// established, which gives an ack word and then a fin word. The rsp port moves
// one word per cycle while rsp_tready is high, so the sustained rate is one event
// per cycle, lower for an event that answers a fin. Port and window registers may
// be written only while no result is pending.
module tcp_connection_control_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // operation
   input  logic [1:0]   req_tuser,
   // seg_flags, seg_seq, seg_ack, payload_len, initial_seq
   input  logic [119:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic         rsp_tlast,
   // send_valid
   output logic         rsp_tuser,
   // send_flags, send_seq, send_ack, send_window, send_src_port,
   // send_dst_port, deliver, dead, phase_now, zero fill
   output logic [127:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);

   logic [15:0] local_port_ff;
   logic [15:0] remote_port_ff;
   logic [15:0] receive_window_ff;
   logic        accept;
   tcc_pkg::rec_type  rec;
   tcc_pkg::word_type word;
   logic [15:0] win;
   logic [15:0] src;
   logic [15:0] dst;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_port_ff     <= '0;
         remote_port_ff    <= '0;
         receive_window_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            tcc_pkg::CSR_LOCAL_PORT:     local_port_ff     <= csr_wdata;
            tcc_pkg::CSR_REMOTE_PORT:    remote_port_ff    <= csr_wdata;
            tcc_pkg::CSR_RECEIVE_WINDOW: receive_window_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   tcc_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .operation   (req_tuser),
      .seg_flags   (req_tdata[7:0]),
      .seg_seq     (req_tdata[39:8]),
      .seg_ack     (req_tdata[71:40]),
      .payload_len (req_tdata[87:72]),
      .initial_seq (req_tdata[119:88]),
      .rec         (rec)
   );

   tcc_rspq u_rspq (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_rec   (rec),
      .has_room   (req_tready),
      .word_valid (rsp_tvalid),
      .word_ready (rsp_tready),
      .word       (word)
   );

   // header fields stay zero on words that carry no segment
   assign win = word.vld ? receive_window_ff : 16'd0;
   assign src = word.vld ? local_port_ff : 16'd0;
   assign dst = word.vld ? remote_port_ff : 16'd0;

   assign rsp_tuser = word.vld;
   assign rsp_tlast = word.last;
   assign rsp_tdata = {3'd0, word.phase, word.dead, word.deliver, dst, src, win,
                       word.ack, word.seq, word.flags};

endmodule

// ----- tb/sv/tcp_connection_control_unit_tb.sv -----
// self-checking testbench of the tcp connection control unit: event stream, reply prediction
module tcp_connection_control_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [7:0] FL_SPARE = ~tcc_pkg::FL_RELEVANT;
   localparam int QUIET_LIMIT = 5000;
   localparam int PHASE_EVENTS = 470;

   // one reply word with every header field spelled out
   typedef struct packed {
      logic        vld;
      logic [7:0]  flags;
      logic [31:0] seq;
      logic [31:0] ack;
      logic [15:0] window;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic        deliver;
      logic        dead;
      logic [2:0]  phase;
      logic        last;
   } reply_word_type;

   class conn_scoreboard;
      logic [15:0] local_port;
      logic [15:0] remote_port;
      logic [15:0] rcv_window;
      logic [2:0]  phase;
      logic [31:0] rcv_nxt;
      logic [31:0] snd_nxt;
      reply_word_type owed_replies[$];
      int          errors;
      int          words_seen;
      int          fin_pairs;
      int          deliveries;
      int          kills;

      function new();
         local_port = '0;
         remote_port = '0;
         rcv_window = '0;
         phase = tcc_pkg::PH_IDLE;
         rcv_nxt = '0;
         snd_nxt = '0;
         errors = 0;
         words_seen = 0;
         fin_pairs = 0;
         deliveries = 0;
         kills = 0;
      endfunction

      function int pending();
         return owed_replies.size();
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] value);
         case (idx)
            tcc_pkg::CSR_LOCAL_PORT:     local_port = value;
            tcc_pkg::CSR_REMOTE_PORT:    remote_port = value;
            tcc_pkg::CSR_RECEIVE_WINDOW: rcv_window = value;
            default: ;
         endcase
      endfunction

      function reply_word_type segment(logic [7:0] flags, logic [31:0] seq,
                                       logic [31:0] ack);
         reply_word_type w;
         w = '0;
         w.vld = 1'b1;
         w.flags = flags;
         w.seq = seq;
         w.ack = ack;
         w.window = rcv_window;
         w.src_port = local_port;
         w.dst_port = remote_port;
         return w;
      endfunction

      // advance the connection by one event and queue the reply words it owes
      function void take_event(logic [1:0] op, logic [7:0] flags, logic [31:0] sseq,
                               logic [31:0] sack, logic [15:0] len, logic [31:0] iseq);
         reply_word_type words[2];
         int          count;
         int          k;
         logic        delivered;
         logic        killed;
         logic [7:0]  rel;
         words[0] = '0;
         words[1] = '0;
         count = 1;
         delivered = 1'b0;
         killed = 1'b0;
         rel = flags & tcc_pkg::FL_RELEVANT;
         case (op)
            tcc_pkg::OP_ACCEPT: begin
               phase = tcc_pkg::PH_ACCEPTING;
               rcv_nxt = sseq + 32'd1;
               snd_nxt = iseq;
               words[0] = segment(tcc_pkg::FL_SYNACK, snd_nxt, rcv_nxt);
            end
            tcc_pkg::OP_CONNECT: begin
               phase = tcc_pkg::PH_CONNECTING;
               snd_nxt = iseq;
               words[0] = segment(tcc_pkg::FL_SYN, snd_nxt, '0);
            end
            tcc_pkg::OP_SEGMENT: begin
               if ((flags & tcc_pkg::FL_RST) != '0) begin
                  phase = tcc_pkg::PH_DEAD;
                  killed = 1'b1;
               end else case (phase)
                  tcc_pkg::PH_ESTABLISHED: begin
                     if (rel == tcc_pkg::FL_FIN) begin
                        // bare fin: ack then fin, both numbered from the peer's view
                        phase = tcc_pkg::PH_PASSIVE_CLOSE;
                        words[0] = segment(tcc_pkg::FL_ACK, sack + 32'd1, sseq + 32'd1);
                        words[1] = segment(tcc_pkg::FL_FIN, sack + 32'd1, sseq + 32'd1);
                        count = 2;
                     end else if (len != '0) begin
                        if (sseq < rcv_nxt) begin
                           words[0] = segment(tcc_pkg::FL_ACK, snd_nxt, rcv_nxt);
                        end else if (sseq == rcv_nxt) begin
                           rcv_nxt = rcv_nxt + 32'(len);
                           delivered = 1'b1;
                           words[0] = segment(tcc_pkg::FL_ACK, snd_nxt, rcv_nxt);
                        end
                     end
                  end
                  tcc_pkg::PH_ACCEPTING: begin
                     if (rel == tcc_pkg::FL_ACK) begin
                        phase = tcc_pkg::PH_ESTABLISHED;
                        rcv_nxt = sseq;
                        snd_nxt = sack;
                     end
                  end
                  tcc_pkg::PH_CONNECTING: begin
                     if (rel == tcc_pkg::FL_SYNACK) begin
                        phase = tcc_pkg::PH_ESTABLISHED;
                        rcv_nxt = sseq + 32'd1;
                        snd_nxt = sack + 32'd1;
                        words[0] = segment(tcc_pkg::FL_ACK, snd_nxt, rcv_nxt);
                     end
                  end
                  tcc_pkg::PH_PASSIVE_CLOSE: begin
                     if (rel == tcc_pkg::FL_ACK) begin
                        phase = tcc_pkg::PH_DEAD;
                        killed = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
         for (k = 0; k < count; k++) begin
            words[k].deliver = delivered;
            words[k].dead = killed;
            words[k].phase = phase;
            words[k].last = (k == count - 1);
            owed_replies.push_back(words[k]);
         end
         if (count == 2) fin_pairs++;
         if (delivered) deliveries++;
         if (killed) kills++;
      endfunction

      task report(string what);
         errors++;
         if (errors <= 30) $display("MISMATCH at %0t: %s", $time, what);
      endtask

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("word %0d %s got %0h want %0h", words_seen, name, got, want));
      endtask

      task match_reply(reply_word_type got);
         reply_word_type want;
         words_seen++;
         if (owed_replies.size() == 0) begin
            report($sformatf("word %0d arrived with nothing owed", words_seen));
         end else begin
            want = owed_replies.pop_front();
            check_field("send_valid", 32'(got.vld), 32'(want.vld));
            check_field("send_flags", 32'(got.flags), 32'(want.flags));
            check_field("send_seq", got.seq, want.seq);
            check_field("send_ack", got.ack, want.ack);
            check_field("send_window", 32'(got.window), 32'(want.window));
            check_field("send_src_port", 32'(got.src_port), 32'(want.src_port));
            check_field("send_dst_port", 32'(got.dst_port), 32'(want.dst_port));
            check_field("deliver", 32'(got.deliver), 32'(want.deliver));
            check_field("dead", 32'(got.dead), 32'(want.dead));
            check_field("phase_now", 32'(got.phase), 32'(want.phase));
            check_field("last", 32'(got.last), 32'(want.last));
         end
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [1:0]   req_tuser;
   logic [119:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic         rsp_tlast;
   logic         rsp_tuser;
   logic [127:0] rsp_tdata;
   logic         csr_we;
   logic [1:0]   csr_addr;
   logic [15:0]  csr_wdata;

   conn_scoreboard track;
   logic           calm;
   int             events_sent;
   int             settings;
   int             stall_left;
   int             quiet_cycles;

   tcp_connection_control_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
         rsp_tready <= 1'b0;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // reply monitor and watchdog
   always @(posedge clock) begin
      reply_word_type got;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.vld = rsp_tuser;
            got.flags = rsp_tdata[7:0];
            got.seq = rsp_tdata[39:8];
            got.ack = rsp_tdata[71:40];
            got.window = rsp_tdata[87:72];
            got.src_port = rsp_tdata[103:88];
            got.dst_port = rsp_tdata[119:104];
            got.deliver = rsp_tdata[120];
            got.dead = rsp_tdata[121];
            got.phase = rsp_tdata[124:122];
            got.last = rsp_tlast;
            track.match_reply(got);
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_event(logic [1:0] op, logic [7:0] flags, logic [31:0] sseq,
                             logic [31:0] sack, logic [15:0] len, logic [31:0] iseq);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {iseq, len, sack, sseq, flags};
      do @(posedge clock); while (!req_tready);
      track.take_event(op, flags, sseq, sack, len, iseq);
      events_sent++;
   endtask

   // always lets at least one edge pass, so valid is never lowered and raised in one step
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (track.pending() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [15:0] value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      track.write_reg(idx, value);
   endtask

   task automatic program_regs(logic [15:0] lport, logic [15:0] rport, logic [15:0] win);
      csr_write(tcc_pkg::CSR_LOCAL_PORT, lport);
      csr_write(tcc_pkg::CSR_REMOTE_PORT, rport);
      csr_write(tcc_pkg::CSR_RECEIVE_WINDOW, win);
      csr_we <= 1'b0;
      settings++;
   endtask

   // one connection: handshake, a burst of data, then close, reset or abandon
   task automatic run_connection();
      int          r;
      int          burst;
      logic [31:0] sseq;
      logic [15:0] len;
      logic [7:0]  flags;
      if ($urandom_range(0, 24) == 0) wait_drained();
      if ($urandom_range(0, 9) == 0)
         send_event(2'($urandom_range(0, 3)), 8'($urandom), $urandom, $urandom,
                    16'($urandom), $urandom);
      if ($urandom_range(0, 1) == 1) begin
         send_event(tcc_pkg::OP_ACCEPT, 8'($urandom), $urandom, $urandom,
                    16'($urandom), $urandom);
         if ($urandom_range(0, 9) < 8)
            send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_ACK | (8'($urandom) & FL_SPARE),
                       $urandom, $urandom, 16'($urandom_range(0, 1460)), $urandom);
      end else begin
         send_event(tcc_pkg::OP_CONNECT, 8'($urandom), $urandom, $urandom,
                    16'($urandom), $urandom);
         if ($urandom_range(0, 9) < 8)
            send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_SYNACK | (8'($urandom) & FL_SPARE),
                       $urandom, $urandom, 16'($urandom_range(0, 1460)), $urandom);
      end
      burst = $urandom_range(1, 14);
      repeat (burst) begin
         r = $urandom_range(0, 99);
         if (r < 60) sseq = track.rcv_nxt;
         else if (r < 75) sseq = track.rcv_nxt - 32'($urandom_range(1, 3000));
         else if (r < 88) sseq = track.rcv_nxt + 32'($urandom_range(1, 3000));
         else sseq = $urandom;
         r = $urandom_range(0, 99);
         if (r < 8) len = '0;
         else if (r < 16) len = 16'($urandom);
         else if (r < 18) len = 16'hFFFF;
         else len = 16'($urandom_range(1, 1460));
         flags = (8'($urandom) & FL_SPARE) |
                 (($urandom_range(0, 19) == 0) ? 8'($urandom) : tcc_pkg::FL_ACK);
         send_event(tcc_pkg::OP_SEGMENT, flags, sseq, $urandom, len, $urandom);
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_FIN | (8'($urandom) & FL_SPARE),
                    $urandom, $urandom, 16'($urandom), $urandom);
         if ($urandom_range(0, 9) < 8)
            send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_ACK | (8'($urandom) & FL_SPARE),
                       $urandom, $urandom, 16'($urandom), $urandom);
      end else if (r < 75) begin
         send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_RST | 8'($urandom), $urandom, $urandom,
                    16'($urandom), $urandom);
      end
   endtask

   task automatic random_phase(int count);
      int target;
      target = events_sent + count;
      while (events_sent < target) run_connection();
   endtask

   initial begin
      track = new();
      calm = 1'b0;
      events_sent = 0;
      settings = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= '0;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_addr <= '0;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_regs(16'h0050, 16'hC350, 16'h2000);
      // unused operation, then stray segments while idle and dead
      send_event(OP_UNUSED, 8'hFF, '1, '1, '1, '1);
      send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_ACK, 32'h10, 32'h20, 16'd5, '0);
      send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_RST, '0, '0, '0, '0);
      send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_FIN, 32'h1, 32'h2, 16'd1, '0);
      // connect with every sequence at the wrap point
      send_event(tcc_pkg::OP_CONNECT, '0, '0, '0, '0, 32'hFFFF_FFFF);
      send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_SYN, '1, '1, '0, '0);
      send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_SYNACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 '0, '0);
      // in order with the largest payload, stale, ahead, empty, odd flag bits
      send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_ACK, '0, '0, 16'hFFFF, '0);
      send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_ACK, '0, '0, 16'd10, '0);
      send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_ACK, 32'h0001_0000, '0, 16'd5, '0);
      send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_ACK, track.rcv_nxt, '0, '0, '0);
      send_event(tcc_pkg::OP_SEGMENT, 8'hEB, track.rcv_nxt, '0, 16'd100, '0);
      // bare fin with spare bits set, numbers wrap to zero
      send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_FIN | FL_SPARE, '1, '1, '0, '0);
      send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_SYNACK, '0, '0, '0, '0);
      send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_ACK, '0, '0, '0, '0);
      // passive open from the peer's largest sequence
      send_event(tcc_pkg::OP_ACCEPT, '0, '1, '0, '0, '0);
      send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_FIN, '0, '0, '0, '0);
      send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_ACK, 32'd5, 32'h0000_ABCD, '0, '0);
      send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_FIN | tcc_pkg::FL_ACK, 32'd5, '0, '0, '0);
      // handshake restarts in the middle of other phases
      send_event(tcc_pkg::OP_CONNECT, '0, '0, '0, '0, 32'h1234_5678);
      send_event(tcc_pkg::OP_ACCEPT, '0, 32'h8000_0000, '0, '0, 32'h8765_4321);
      send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_RST | tcc_pkg::FL_ACK, '0, '0, '0, '0);
      send_event(OP_UNUSED, '0, '0, '0, '0, '0);
      send_event(tcc_pkg::OP_ACCEPT, '0, 32'd99, '0, '0, 32'd7);
      send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_ACK, 32'd100, 32'd8, '0, '0);
      send_event(tcc_pkg::OP_SEGMENT, tcc_pkg::FL_RST | tcc_pkg::FL_ACK, 32'd100, 32'd8,
                 16'd20, '0);
      wait_drained();

      program_regs('0, '0, '0);
      random_phase(PHASE_EVENTS);
      wait_drained();
      program_regs('1, '1, '1);
      calm = 1'b1;
      random_phase(PHASE_EVENTS);
      calm = 1'b0;
      wait_drained();
      program_regs(16'($urandom), 16'($urandom), 16'($urandom));
      random_phase(PHASE_EVENTS);
      wait_drained();
      program_regs(16'($urandom), 16'($urandom), 16'($urandom));
      random_phase(PHASE_EVENTS);
      wait_drained();
      repeat (8) @(posedge clock);

      if (track.pending() != 0)
         track.report($sformatf("%0d reply words never arrived", track.pending()));
      $display("ran %0d events, checked %0d reply words under %0d register settings",
               events_sent, track.words_seen, settings);
      $display("saw %0d fin answer pairs, %0d in-order deliveries, %0d teardowns",
               track.fin_pairs, track.deliveries, track.kills);
      if (track.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
